### rtl/core/dual_pot_moving_average_mapper_top_macros.svh
// Assertion macros for the moving-average mapper top level.
`ifndef DUAL_POT_MOVING_AVERAGE_MAPPER_TOP_MACROS_SVH
`define DUAL_POT_MOVING_AVERAGE_MAPPER_TOP_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DPMA_ASSERT_HOLDS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("dpma: invariant violated");

// A consequence that must hold in the cycle after its trigger.
`define DPMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dpma: next-cycle check failed");

`endif

### rtl/core/dpma_pkg.sv
// Types, constants and helper functions for the moving-average mapper.
package dpma_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 8;
  localparam int DELAY_W  = 6;
  localparam int BPROD_W  = 18;
  localparam int SPROD_W  = 16;

  localparam logic CMD_PRIME  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  localparam int                  SAMPLE_MAX  = 1023;
  localparam int                  SCALE_SHIFT = 10;
  localparam logic [SAMPLE_W-1:0] LEVEL_KNEE  = 10'd1017;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX   = 8'd255;
  localparam logic [LEVEL_W-1:0]  LEVEL_FLOOR = 8'd32;
  localparam logic [LEVEL_W-1:0]  LEVEL_SPAN  = 8'd223;
  localparam logic [DELAY_W-1:0]  DELAY_MAX   = 6'd60;
  localparam logic [DELAY_W-1:0]  DELAY_MIN   = 6'd10;
  localparam logic [DELAY_W-1:0]  DELAY_SPAN  = 6'd50;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] bright_sample;
    logic [SAMPLE_W-1:0] speed_sample;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] bright_average;
    logic [SAMPLE_W-1:0] speed_average;
    logic [LEVEL_W-1:0]  brightness_level;
    logic [DELAY_W-1:0]  frame_delay_ms;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] bright;
    logic [SAMPLE_W-1:0] speed;
  } sample_pair_t;

  typedef struct packed {
    logic load_prod;
    logic load_out;
  } stage_ctl_t;

  // Floor division by 1023 = 2^10 - 1, exact while the quotient stays below 256 (the LEVEL_W-bit result).
  function automatic logic [LEVEL_W-1:0] div_full_scale(input logic [BPROD_W-1:0] x);
    logic [BPROD_W-1:0] acc;
    acc = x + (x >> SCALE_SHIFT) + BPROD_W'(1);
    return LEVEL_W'(acc >> SCALE_SHIFT);
  endfunction

endpackage

### rtl/core/dpma_ring.sv
// Sample rings and running sums for both channels, updated as each request is taken.
module dpma_ring
  import dpma_pkg::*;
#(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  in_t              item,
  output logic [SUM_W-1:0] bright_sum,
  output logic [SUM_W-1:0] speed_sum
);

  localparam int POS_W = $clog2(WINDOW);

  sample_pair_t      mem [WINDOW];
  sample_pair_t      rd_data;
  sample_pair_t      prime_pair;
  sample_pair_t      old_pair;
  logic [WINDOW-1:0] written;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic              update;
  logic              prime;

  assign update = load && (item.cmd == CMD_UPDATE);
  assign prime  = load && (item.cmd == CMD_PRIME);

  always_comb begin
    pos_next = pos;
    if (update) begin
      pos_next = (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
    end
  end

  // An entry not written since the last prime (or reset) holds the primed value.
  assign old_pair = written[pos] ? rd_data : prime_pair;

  // The read is registered ahead of use, at the position the next request will use.
  always_ff @(posedge clk) begin
    if (update) begin
      mem[pos] <= {item.bright_sample, item.speed_sample};
    end
    rd_data <= mem[pos_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      written    <= '0;
      prime_pair <= '0;
      bright_sum <= '0;
      speed_sum  <= '0;
    end else begin
      pos <= pos_next;
      if (prime) begin
        written    <= '0;
        prime_pair <= {item.bright_sample, item.speed_sample};
        bright_sum <= SUM_W'(item.bright_sample) * SUM_W'(WINDOW);
        speed_sum  <= SUM_W'(item.speed_sample) * SUM_W'(WINDOW);
      end else if (update) begin
        written[pos] <= 1'b1;
        bright_sum   <= bright_sum - SUM_W'(old_pair.bright) + SUM_W'(item.bright_sample);
        speed_sum    <= speed_sum - SUM_W'(old_pair.speed) + SUM_W'(item.speed_sample);
      end
    end
  end

endmodule

### rtl/core/dpma_div.sv
// Divides both running sums by the window length using a reciprocal multiply.
module dpma_div
  import dpma_pkg::*;
#(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 14
) (
  input  logic             clk,
  input  logic             load,
  input  logic [SUM_W-1:0] bright_sum,
  input  logic [SUM_W-1:0] speed_sum,
  output sample_pair_t     avg
);

  localparam int     LOG_W     = $clog2(WINDOW);
  localparam int     SHIFT     = SUM_W + LOG_W;
  localparam int     PROD_W    = 2 * SUM_W + 1;
  localparam longint RECIP_VAL = ((longint'(1) << SHIFT) + longint'(WINDOW) - 1)
                                 / longint'(WINDOW);
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(RECIP_VAL);

  logic [PROD_W-1:0] bright_prod;
  logic [PROD_W-1:0] speed_prod;

  // The rounded-up reciprocal gives the exact floor for every sum of SUM_W bits.
  assign bright_prod = PROD_W'(bright_sum) * PROD_W'(RECIP);
  assign speed_prod  = PROD_W'(speed_sum) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      avg.bright <= bright_prod[SHIFT +: SAMPLE_W];
      avg.speed  <= speed_prod[SHIFT +: SAMPLE_W];
    end
  end

endmodule

### rtl/core/dpma_map.sv
// Maps the averages onto a display brightness level and a frame delay.
module dpma_map
  import dpma_pkg::*;
(
  input  logic         clk,
  input  stage_ctl_t   ctl,
  input  sample_pair_t avg,
  output out_t         result
);

  sample_pair_t       avg_q;
  logic [BPROD_W-1:0] bright_prod;
  logic [SPROD_W-1:0] speed_prod;
  logic [LEVEL_W-1:0] bright_q;
  logic [LEVEL_W-1:0] speed_q;
  out_t               result_next;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      avg_q       <= avg;
      bright_prod <= BPROD_W'(avg.bright) * BPROD_W'(LEVEL_SPAN);
      speed_prod  <= SPROD_W'(avg.speed) * SPROD_W'(DELAY_SPAN);
    end
  end

  assign bright_q = div_full_scale(bright_prod);
  assign speed_q  = div_full_scale(BPROD_W'(speed_prod));

  always_comb begin
    result_next.bright_average = avg_q.bright;
    result_next.speed_average  = avg_q.speed;
    if (avg_q.bright > LEVEL_KNEE) begin
      result_next.brightness_level = LEVEL_MAX;
    end else begin
      result_next.brightness_level = bright_q + LEVEL_FLOOR;
    end
    result_next.frame_delay_ms = DELAY_MAX - DELAY_W'(speed_q);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result <= result_next;
    end
  end

endmodule

### rtl/core/dual_pot_moving_average_mapper_top.sv
// Top level of the dual potentiometer moving-average mapper.
//
// Requests arrive on req_valid/req_ready/req_data, each carrying a command
// and one brightness and one speed sample. A prime command fills both
// windows with its samples; an update command replaces the oldest entry
// of each window. Every request yields exactly one result on
// res_valid/res_ready/res_data: both averages, a brightness level and a
// frame delay.
// The datapath is a four-register pipeline: sums, averages, scaled
// products and the result register. A result becomes valid once its
// request has passed the sums, averages and products registers, and one
// request can be taken every cycle unless the receiver stalls; the window
// memory is read ahead so its single read port never limits the rate.
// When the receiver stalls, results are held and the pipeline fills; a new
// request is still taken while any stage ahead of the stalled result is
// free, and req_ready drops once all four stages are full.
// Reset clears the windows, sums and pipeline at once; no clearing pass
// follows, and the block takes requests as soon as reset is released.
module dual_pot_moving_average_mapper_top
  import dpma_pkg::*;
#(
  parameter int WINDOW = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  in_t  req_data,
  output logic res_valid,
  input  logic res_ready,
  output out_t res_data
);

  localparam int SUM_W = $clog2(WINDOW * SAMPLE_MAX + 1);

  logic             accept;
  logic             sum_valid;
  logic             avg_valid;
  logic             prod_valid;
  logic             load_avg;
  stage_ctl_t       ctl;
  logic [SUM_W-1:0] bright_sum;
  logic [SUM_W-1:0] speed_sum;
  sample_pair_t     avg;

  assign ctl.load_out  = prod_valid && (!res_valid || res_ready);
  assign ctl.load_prod = avg_valid && (!prod_valid || ctl.load_out);
  assign load_avg      = sum_valid && (!avg_valid || ctl.load_prod);
  assign req_ready     = !sum_valid || load_avg;
  assign accept        = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid  <= 1'b0;
      avg_valid  <= 1'b0;
      prod_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (accept) begin
        sum_valid <= 1'b1;
      end else if (load_avg) begin
        sum_valid <= 1'b0;
      end
      if (load_avg) begin
        avg_valid <= 1'b1;
      end else if (ctl.load_prod) begin
        avg_valid <= 1'b0;
      end
      if (ctl.load_prod) begin
        prod_valid <= 1'b1;
      end else if (ctl.load_out) begin
        prod_valid <= 1'b0;
      end
      if (ctl.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  dpma_ring #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_ring (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .item       (req_data),
    .bright_sum (bright_sum),
    .speed_sum  (speed_sum)
  );

  dpma_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .clk        (clk),
    .load       (load_avg),
    .bright_sum (bright_sum),
    .speed_sum  (speed_sum),
    .avg        (avg)
  );

  dpma_map u_map (
    .clk    (clk),
    .ctl    (ctl),
    .avg    (avg),
    .result (res_data)
  );

`include "dual_pot_moving_average_mapper_top_macros.svh"

  // The running sums never exceed a full window of maximum samples.
  `DPMA_ASSERT_HOLDS(a_sum_bound, (bright_sum <= SUM_W'(WINDOW * SAMPLE_MAX)) && (speed_sum <= SUM_W'(WINDOW * SAMPLE_MAX)))
  // A prime request sets the brightness sum to a whole window of its sample.
  `DPMA_ASSERT_NEXT(a_prime_sum, accept && (req_data.cmd == CMD_PRIME), bright_sum == SUM_W'($past(req_data.bright_sample)) * SUM_W'(WINDOW))
  // The brightness level never drops below its floor.
  `DPMA_ASSERT_HOLDS(a_level_floor, !res_valid || (res_data.brightness_level >= LEVEL_FLOOR))
  // The frame delay stays within its mapped span.
  `DPMA_ASSERT_HOLDS(a_delay_span, !res_valid || ((res_data.frame_delay_ms >= DELAY_MIN) && (res_data.frame_delay_ms <= DELAY_MAX)))

endmodule

### sim/tb_top.sv
// Self-checking testbench for the dual potentiometer moving-average mapper.
module tb_top;
  import dpma_pkg::*;

  localparam int WINDOW         = 10;
  localparam int RANDOM_ITEMS   = 1830;
  localparam int IDLE_PCT       = 11;
  localparam int CALM_FIRST     = 700;
  localparam int CALM_LAST      = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req_data  = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  out_t res_data;

  dual_pot_moving_average_mapper_top #(
    .WINDOW(WINDOW)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  always #4 clk = ~clk;

  in_t  sample_requests[$];
  out_t awaited_results[$];

  // Window contents and running sums as the block should hold them.
  logic [SAMPLE_W-1:0] bright_window[WINDOW];
  logic [SAMPLE_W-1:0] speed_window[WINDOW];
  int unsigned         window_slot;
  int unsigned         bright_total;
  int unsigned         speed_total;

  int unsigned requests_taken = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  // Both sides run without idling while this stretch of requests goes through.
  function automatic bit calm_stretch();
    return requests_taken >= CALM_FIRST && requests_taken < CALM_LAST;
  endfunction

  function automatic out_t average_and_map(in_t r);
    out_t        o;
    int unsigned bavg;
    int unsigned savg;
    if (r.cmd == CMD_PRIME) begin
      for (int i = 0; i < WINDOW; i++) begin
        bright_window[i] = r.bright_sample;
        speed_window[i]  = r.speed_sample;
      end
      bright_total = r.bright_sample * WINDOW;
      speed_total  = r.speed_sample * WINDOW;
    end else begin
      bright_total = bright_total - bright_window[window_slot] + r.bright_sample;
      speed_total  = speed_total - speed_window[window_slot] + r.speed_sample;
      bright_window[window_slot] = r.bright_sample;
      speed_window[window_slot]  = r.speed_sample;
      window_slot = (window_slot + 1 >= WINDOW) ? 0 : window_slot + 1;
    end
    bavg = bright_total / WINDOW;
    savg = speed_total / WINDOW;
    o.bright_average   = SAMPLE_W'(bavg);
    o.speed_average    = SAMPLE_W'(savg);
    o.brightness_level = (bavg > 1017) ? 8'd255 : LEVEL_W'(bavg * 223 / 1023 + 32);
    o.frame_delay_ms   = DELAY_W'(60 - savg * 50 / 1023);
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic add_request(logic cmd, int unsigned bright, int unsigned speed);
    in_t r;
    r.cmd           = cmd;
    r.bright_sample = SAMPLE_W'(bright);
    r.speed_sample  = SAMPLE_W'(speed);
    sample_requests.push_back(r);
  endtask

  function automatic int unsigned pick_sample();
    case ($urandom_range(9, 0))
      0:       return 0;
      1:       return 1023;
      2:       return $urandom_range(1023, 1008);
      3:       return $urandom_range(15, 0);
      default: return $urandom_range(1023, 0);
    endcase
  endfunction

  function automatic int unsigned near_sample(int unsigned base);
    int v;
    v = int'(base) + int'($urandom_range(8, 0)) - 4;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // Driver: a request stays on the port until the block takes it.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        awaited_results.push_back(average_and_map(req_data));
        requests_taken++;
      end
      if (!req_valid || req_ready) begin
        if (sample_requests.size() != 0 &&
            (calm_stretch() || $urandom_range(99, 0) >= IDLE_PCT)) begin
          req_data  <= sample_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result taken is checked against the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      res_ready <= calm_stretch() || $urandom_range(99, 0) >= IDLE_PCT;
      if (res_valid && res_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("MISMATCH: unexpected result %p", res_data);
        end else begin
          want = awaited_results.pop_front();
          check_field("bright_average", want.bright_average, res_data.bright_average);
          check_field("speed_average", want.speed_average, res_data.speed_average);
          check_field("brightness_level", want.brightness_level,
                      res_data.brightness_level);
          check_field("frame_delay_ms", want.frame_delay_ms, res_data.frame_delay_ms);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned bright_base;
    int unsigned speed_base;
    int unsigned burst_len;
    int unsigned queued;

    for (int i = 0; i < WINDOW; i++) begin
      bright_window[i] = '0;
      speed_window[i]  = '0;
    end
    window_slot  = 0;
    bright_total = 0;
    speed_total  = 0;

    // Directed: the cleared windows, both ends of the scale, the brightness
    // knee, a prime part-way round the ring and a full wrap of the ring.
    add_request(CMD_UPDATE, 0, 0);
    add_request(CMD_PRIME, 1023, 1023);
    add_request(CMD_PRIME, 0, 0);
    add_request(CMD_PRIME, 1017, 1017);
    add_request(CMD_PRIME, 1018, 1018);
    for (int i = 0; i < 3; i++) add_request(CMD_UPDATE, 1023, 0);
    add_request(CMD_PRIME, 512, 300);
    for (int i = 0; i < 10; i++) add_request(CMD_UPDATE, 1023, 1023);
    add_request(CMD_UPDATE, 0, 1023);
    add_request(CMD_UPDATE, 10'h2AA, 10'h155);

    // Random: bursts of updates around a level so that the averages settle,
    // with some primes and fully random samples mixed in.
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(99, 0) < 12) begin
        add_request(CMD_PRIME, pick_sample(), pick_sample());
        queued++;
      end else begin
        bright_base = pick_sample();
        speed_base  = pick_sample();
        burst_len   = $urandom_range(16, 1);
        for (int i = 0; i < burst_len; i++) begin
          if ($urandom_range(3, 0) == 0)
            add_request(CMD_UPDATE, $urandom_range(1023, 0), $urandom_range(1023, 0));
          else
            add_request(CMD_UPDATE, near_sample(bright_base), near_sample(speed_base));
          queued++;
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (sample_requests.size() != 0 || req_valid || awaited_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
